/* rtl/core/lfr_pkg.sv */
// Package for the LED fade ramp: field widths, controller states and the
// request structure passed to the bit-serial divider. No dependencies.
package lfr_pkg;

  localparam int LEVEL_W = 8;
  localparam int DUR_W   = 16;
  localparam int CNT_W   = $clog2(DUR_W);

  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DUR_W - 1);
  localparam logic [DUR_W-1:0] ELAPSED_MAX = {DUR_W{1'b1}};

  localparam logic ACT_FADE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } lfr_state_t;

  typedef struct packed {
    logic               start;
    logic [DUR_W-1:0]   dividend;
    logic [LEVEL_W-1:0] divisor;
  } lfr_div_req_t;

endpackage

/* rtl/core/led_fade_ramp_top.sv */
// LED fade ramp engine: ticks and fade requests in, one result per transaction.
// The result is registered in the cycle after the input is accepted.
// Ticks and same-level requests are taken one per cycle while the output is
// not stalled; a request with a new target holds off input while the
// bit-serial divider forms the step interval, one quotient bit per cycle.
// Reset (rst_n, synchronous) clears level, goal, interval and elapsed count.
module led_fade_ramp_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_action,
  input  logic [lfr_pkg::LEVEL_W-1:0]   in_target_level,
  input  logic [lfr_pkg::DUR_W-1:0]     in_duration_ms,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lfr_pkg::LEVEL_W-1:0]   out_level_out,
  output logic                          out_level_written,
  output logic                          out_fade_active
);
  import lfr_pkg::*;

  lfr_state_t         state_r, state_nxt;
  logic [LEVEL_W-1:0] cur_r, cur_nxt;
  logic [LEVEL_W-1:0] goal_r, goal_nxt;
  logic [DUR_W-1:0]   interval_r, interval_nxt;
  logic [DUR_W-1:0]   elapsed_r, elapsed_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [LEVEL_W-1:0] out_level_r;
  logic               out_written_r;
  logic               out_active_r;

  logic               accept;
  logic               slot_free;
  logic               new_target;
  logic [LEVEL_W-1:0] lvl_gap;
  logic [DUR_W-1:0]   elapsed_inc;
  logic               step;
  lfr_div_req_t       div_req;
  logic               div_done;
  logic [DUR_W-1:0]   div_quo;

  lfr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign slot_free = !out_valid_r || !out_stall;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    new_target  = (in_action == ACT_FADE) && (in_target_level != cur_r);
    lvl_gap     = (cur_r < in_target_level) ? (in_target_level - cur_r)
                                            : (cur_r - in_target_level);
    elapsed_inc = (elapsed_r == ELAPSED_MAX) ? elapsed_r : elapsed_r + 1'b1;
    step        = (cur_r != goal_r) && (elapsed_inc >= interval_r);
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept && new_target) state_nxt = ST_DIV;
      ST_DIV:  if (div_done) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Controller outputs.
  always_comb begin
    in_stall         = 1'b1;
    div_req.start    = 1'b0;
    div_req.dividend = in_duration_ms;
    div_req.divisor  = lvl_gap;
    case (state_r)
      ST_IDLE: begin
        in_stall      = !slot_free;
        div_req.start = accept && new_target;
      end
      ST_DIV:  in_stall = 1'b1;
      default: in_stall = 1'b1;
    endcase
  end

  // Level, goal and timing state, plus the result of the accepted item.
  always_comb begin
    cur_nxt       = cur_r;
    goal_nxt      = goal_r;
    interval_nxt  = interval_r;
    elapsed_nxt   = elapsed_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (state_r == ST_DIV && div_done) begin
      interval_nxt = div_quo;
    end
    if (accept) begin
      out_valid_nxt = 1'b1;
      if (in_action == ACT_TICK) begin
        elapsed_nxt = elapsed_inc;
        if (step) begin
          cur_nxt     = (cur_r < goal_r) ? cur_r + 1'b1 : cur_r - 1'b1;
          elapsed_nxt = '0;
        end
      end else if (new_target) begin
        goal_nxt    = in_target_level;
        elapsed_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_r       <= '0;
      goal_r      <= '0;
      interval_r  <= '0;
      elapsed_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      goal_r      <= goal_nxt;
      interval_r  <= interval_nxt;
      elapsed_r   <= elapsed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_level_r   <= cur_nxt;
      out_written_r <= (in_action == ACT_TICK) && step;
      out_active_r  <= (cur_nxt != goal_nxt);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_level_out     = out_level_r;
  assign out_level_written = out_written_r;
  assign out_fade_active   = out_active_r;

endmodule

/* rtl/core/lfr_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle, 16 by 8 bits.
// Depends on lfr_pkg for widths and the request structure.
module lfr_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lfr_pkg::lfr_div_req_t       req,
  output logic                        done,
  output logic [lfr_pkg::DUR_W-1:0]   quotient
);
  import lfr_pkg::*;

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [LEVEL_W:0]   rem_r;
  logic [DUR_W-1:0]   quo_r;
  logic [LEVEL_W-1:0] div_r;

  logic [LEVEL_W:0]   rem_sh;
  logic [LEVEL_W:0]   diff;
  logic               ge;

  // The remainder stays below the divisor, so its top bit is always free
  // to take the next dividend bit without overflow.
  always_comb begin
    rem_sh = {rem_r[LEVEL_W-1:0], quo_r[DUR_W-1]};
    ge     = (rem_sh >= {1'b0, div_r});
    diff   = rem_sh - {1'b0, div_r};
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      div_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff : rem_sh;
      quo_r <= {quo_r[DUR_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* dv/led_fade_ramp_top_tb.sv */
// Self-checking testbench for led_fade_ramp_top: fade requests and ticks in,
// one level result per transaction out. Depends on lfr_pkg and the RTL only.
module led_fade_ramp_top_tb;

  import lfr_pkg::*;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               written;
    logic               active;
  } fade_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_action = ACT_TICK;
  logic [LEVEL_W-1:0] in_target_level = '0;
  logic [DUR_W-1:0]   in_duration_ms = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [LEVEL_W-1:0] out_level_out;
  logic               out_level_written;
  logic               out_fade_active;

  // Predicted state of the fade engine.
  logic [LEVEL_W-1:0] lvl_now = '0;
  logic [LEVEL_W-1:0] goal_lvl = '0;
  logic [DUR_W-1:0]   step_ivl = '0;
  logic [DUR_W-1:0]   elapsed_ms = '0;

  fade_result_t pending_levels_q[$];
  fade_result_t seen_exp;

  int fail_count = 0;
  int fade_reqs = 0;
  int tick_count = 0;
  int results_seen = 0;
  int writes_seen = 0;
  int burst_left = 0;
  int rx_mode = 0;
  int rx_left = 0;
  bit rx_free = 1'b0;

  led_fade_ramp_top DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_target_level   (in_target_level),
    .in_duration_ms    (in_duration_ms),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_level_out     (out_level_out),
    .out_level_written (out_level_written),
    .out_fade_active   (out_fade_active)
  );

  always #4 clk = ~clk;

  function automatic fade_result_t predict_fade_step(input logic act,
                                                     input logic [LEVEL_W-1:0] tgt,
                                                     input logic [DUR_W-1:0] dur);
    fade_result_t r;
    logic [LEVEL_W-1:0] gap;
    r.written = 1'b0;
    if (act == ACT_FADE) begin
      fade_reqs++;
      // A request for the level already shown leaves any running fade alone.
      if (tgt != lvl_now) begin
        goal_lvl = tgt;
        gap = (lvl_now < tgt) ? tgt - lvl_now : lvl_now - tgt;
        step_ivl = dur / {{(DUR_W-LEVEL_W){1'b0}}, gap};
        elapsed_ms = '0;
      end
    end else begin
      tick_count++;
      if (elapsed_ms != ELAPSED_MAX) elapsed_ms = elapsed_ms + 1'b1;
      if (lvl_now != goal_lvl && elapsed_ms >= step_ivl) begin
        lvl_now = (lvl_now < goal_lvl) ? lvl_now + 1'b1 : lvl_now - 1'b1;
        elapsed_ms = '0;
        r.written = 1'b1;
      end
    end
    r.level = lvl_now;
    r.active = (lvl_now != goal_lvl);
    return r;
  endfunction

  // Starts and ends on a falling edge; valid stays high for a following item.
  task automatic send_item(input logic act, input logic [LEVEL_W-1:0] tgt,
                           input logic [DUR_W-1:0] dur);
    in_valid <= 1'b1;
    in_action <= act;
    in_target_level <= tgt;
    in_duration_ms <= dur;
    do @(posedge clk); while (in_stall);
    pending_levels_q.push_back(predict_fade_step(act, tgt, dur));
    @(negedge clk);
  endtask

  task automatic idle_for(input int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic send_tick();
    send_item(ACT_TICK, LEVEL_W'($urandom), DUR_W'($urandom));
  endtask

  // Sender pacing: bursts of random length, random gaps, the odd long pause.
  task automatic send_paced(input logic act, input logic [LEVEL_W-1:0] tgt,
                            input logic [DUR_W-1:0] dur);
    send_item(act, tgt, dur);
    if (burst_left == 0) begin
      if ($urandom_range(0, 15) == 0) idle_for($urandom_range(20, 40));
      else idle_for($urandom_range(1, 10));
      burst_left = $urandom_range(1, 24);
    end else begin
      burst_left--;
    end
  endtask

  task automatic check_directed_ramps();
    send_tick();                        // idle tick straight after reset
    send_item(ACT_FADE, 8'd0, 16'hFFFF); // same level, ignored
    send_item(ACT_FADE, 8'd2, 16'd0);    // zero interval: a step on every tick
    repeat (3) send_tick();
    send_item(ACT_FADE, 8'd0, 16'd5);    // interval two, ramping down
    repeat (5) send_tick();
    send_item(ACT_FADE, 8'd255, 16'd255);
    repeat (2) send_tick();
    send_item(ACT_FADE, lvl_now, 16'd0); // same level mid-fade: the fade goes on
    send_tick();
    send_item(ACT_FADE, 8'd0, 16'hFFFF);
    send_tick();
    send_item(ACT_FADE, 8'h55, 16'h5555);
    send_tick();
  endtask

  // One-step fade with a long interval: the level moves only on the last tick.
  task automatic check_slowest_step();
    logic [LEVEL_W-1:0] tgt;
    tgt = (lvl_now == 8'd255) ? 8'd254 : lvl_now + 1'b1;
    rx_free = 1'b1;
    send_item(ACT_FADE, tgt, 16'd40);
    repeat (40) send_tick();
    rx_free = 1'b0;
    idle_for(1);
  endtask

  task automatic check_random_fades();
    int issued;
    int kind;
    int n;
    logic [LEVEL_W-1:0] tgt;
    logic [LEVEL_W-1:0] gap;
    logic [DUR_W-1:0] dur;
    issued = 0;
    while (issued < 590) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        tgt = LEVEL_W'($urandom);
        if (tgt == lvl_now) tgt = ~tgt;
        gap = (lvl_now < tgt) ? tgt - lvl_now : lvl_now - tgt;
        // Mostly short intervals so that fades make visible progress.
        if ($urandom_range(0, 9) < 7) dur = DUR_W'($urandom_range(0, 3 * gap));
        else dur = DUR_W'($urandom);
        send_paced(ACT_FADE, tgt, dur);
        n = $urandom_range(1, 40);
        repeat (n) send_paced(ACT_TICK, LEVEL_W'($urandom), DUR_W'($urandom));
        issued += n + 1;
      end else if (kind == 7) begin
        send_paced(ACT_FADE, lvl_now, DUR_W'($urandom));
        n = $urandom_range(1, 8);
        repeat (n) send_paced(ACT_TICK, LEVEL_W'($urandom), DUR_W'($urandom));
        issued += n + 1;
      end else if (kind == 8) begin
        n = $urandom_range(1, 10);
        repeat (n) send_paced(1'($urandom), LEVEL_W'($urandom), DUR_W'($urandom));
        issued += n;
      end else begin
        n = $urandom_range(1, 30);
        repeat (n) send_paced(ACT_TICK, LEVEL_W'($urandom), DUR_W'($urandom));
        issued += n;
      end
    end
    idle_for(1);
  endtask

  // Receiver stall pattern: randomly chosen stall modes, switched at random.
  always @(negedge clk) begin
    if (rx_free) begin
      out_stall <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(20, 120);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 1) == 1);
        default: out_stall <= ((rx_left % 8) < 5);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_levels_q.size() == 0) begin
        $error("unexpected result: level_out %0d", out_level_out);
        fail_count++;
      end else begin
        seen_exp = pending_levels_q.pop_front();
        results_seen++;
        if (out_level_written) writes_seen++;
        if (out_level_out !== seen_exp.level) begin
          $error("level_out: expected %0d, got %0d", seen_exp.level, out_level_out);
          fail_count++;
        end
        if (out_level_written !== seen_exp.written) begin
          $error("level_written: expected %0d, got %0d", seen_exp.written,
                 out_level_written);
          fail_count++;
        end
        if (out_fade_active !== seen_exp.active) begin
          $error("fade_active: expected %0d, got %0d", seen_exp.active,
                 out_fade_active);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #(8 * 1000000);
    $display("Timeout: results still outstanding: %0d", pending_levels_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    check_directed_ramps();
    check_slowest_step();
    check_random_fades();
    while (pending_levels_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Covered %0d transactions: %0d fade requests and %0d ticks.",
             results_seen, fade_reqs, tick_count);
    $display("Level writes observed: %0d; checks failed: %0d.", writes_seen, fail_count);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
